// ===== hdl/acrr_pkg.sv =====
// Shared types and default sizes for the associative store with round-robin replacement.
// Depends on nothing; imported by the top level, the storage block and the checker.
package acrr_pkg;

  // Default store geometry
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_VALUE_BITS = 64;

  // Fixed field widths on the ports
  localparam int OP_W      = 2;
  localparam int KEY_W     = 64;
  localparam int VALUE_W   = 64;
  localparam int COUNT_W   = 5;
  localparam int IN_DATA_W = KEY_W + VALUE_W;
  localparam int OUT_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  // Operation codes carried on in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

endpackage

// ===== hdl/acrr_store.sv =====
// Key and value memories of the store: one write port each, one registered read port each.
// Depends on acrr_pkg (import only; sizes come in as parameters).
module acrr_store
  import acrr_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk,
  // key port
  input  logic                  key_we,
  input  logic [IDX_W-1:0]      key_waddr,
  input  logic [KEY_BITS-1:0]   key_wdata,
  input  logic                  key_re,
  input  logic [IDX_W-1:0]      key_raddr,
  output logic [KEY_BITS-1:0]   key_rdata,
  // value port
  input  logic                  val_we,
  input  logic [IDX_W-1:0]      val_waddr,
  input  logic [VALUE_BITS-1:0] val_wdata,
  input  logic                  val_re,
  input  logic [IDX_W-1:0]      val_raddr,
  output logic [VALUE_BITS-1:0] val_rdata
);

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [KEY_BITS-1:0]   key_q_r;
  logic [VALUE_BITS-1:0] val_q_r;

  // Key memory: write, then registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (key_re) begin
      key_q_r <= key_mem[key_raddr];
    end
  end

  // Value memory: write, then registered read
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (val_re) begin
      val_q_r <= val_mem[val_raddr];
    end
  end

  assign key_rdata = key_q_r;
  assign val_rdata = val_q_r;

endmodule

// ===== hdl/assoc_cache_round_robin.sv =====
// Fully associative key/value store, round-robin victim once full.
// Get/put scan the filled slots (one key compare per cycle) and then give a result word;
// clear and the spare code give a result word without a scan.
// One word at a time: in_tready is low while busy, so no new word is taken until the result is loaded.
// Reset (rst_n low, synchronous): store empty, victim pointer zero, no result pending.
// Depends on acrr_pkg and acrr_store.
module assoc_cache_round_robin
  import acrr_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [63:0] key, [127:64] value_in
  input  logic [OP_W-1:0]       in_tuser,   // [1:0] operation
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [63:0] value_out, [68:64] entry_count, rest 0
  output logic                  out_tuser   // [0] status (1 = get missed)
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

  state_t                  state_r;
  op_t                     op_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [VALUE_BITS-1:0]   val_r;
  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        victim_r;
  logic [CNT_W-1:0]        idx_r;
  logic                    q_vld_r;
  logic [IDX_W-1:0]        q_idx_r;
  logic                    miss_r;
  logic                    sel_val_r;
  logic                    out_tvalid_r;
  logic                    out_status_r;
  logic [VALUE_W-1:0]      out_value_r;
  logic [COUNT_W-1:0]      out_count_r;

  logic                    in_acc;
  logic                    more;
  logic                    hit;
  logic                    miss;
  logic                    full;
  logic                    out_free;
  logic [IDX_W-1:0]        target;
  logic [KEY_BITS-1:0]     key_q;
  logic [VALUE_BITS-1:0]   val_q;
  logic                    key_we;
  logic                    val_we;
  logic [IDX_W-1:0]        val_waddr;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Scan: issue one key read per cycle, compare the one read last cycle
  assign more   = (state_r == ST_SCAN) && (idx_r < count_r);
  assign hit    = (state_r == ST_SCAN) && q_vld_r && (key_q == key_r);
  assign miss   = (state_r == ST_SCAN) && !q_vld_r && !more;
  assign full   = (count_r >= FULL);
  assign target = full ? victim_r : count_r[IDX_W-1:0];

  // Write on a put: value only on a hit, key and value into the target on a miss
  assign key_we    = miss && (op_r == OP_PUT);
  assign val_we    = (hit || miss) && (op_r == OP_PUT);
  assign val_waddr = hit ? q_idx_r : target;

  acrr_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk       (clk),
    .key_we    (key_we),
    .key_waddr (target),
    .key_wdata (key_r),
    .key_re    (more),
    .key_raddr (idx_r[IDX_W-1:0]),
    .key_rdata (key_q),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_r),
    .val_re    (hit),
    .val_raddr (q_idx_r),
    .val_rdata (val_q)
  );

  // Sequencer, store bookkeeping and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      victim_r     <= '0;
      q_vld_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Drop a taken result word unless a new one is loaded this cycle
      if (out_tvalid_r && out_tready && (state_r != ST_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r      <= op_t'(in_tuser);
            key_r     <= in_tdata[KEY_BITS-1:0];
            val_r     <= in_tdata[KEY_W +: VALUE_BITS];
            idx_r     <= '0;
            q_vld_r   <= 1'b0;
            miss_r    <= 1'b0;
            sel_val_r <= 1'b0;
            priority case (op_t'(in_tuser))
              OP_GET, OP_PUT: state_r <= ST_SCAN;
              OP_CLEAR: begin
                count_r  <= '0;
                victim_r <= '0;
                state_r  <= ST_OUT;
              end
              default: state_r <= ST_OUT;
            endcase
          end
        end
        ST_SCAN: begin
          q_vld_r <= more;
          q_idx_r <= idx_r[IDX_W-1:0];
          if (more) begin
            idx_r <= idx_r + 1'b1;
          end
          if (hit) begin
            sel_val_r <= (op_r == OP_GET);
            state_r   <= ST_OUT;
          end else if (miss) begin
            miss_r  <= (op_r == OP_GET);
            state_r <= ST_OUT;
            if (op_r == OP_PUT) begin
              if (full) begin
                victim_r <= (victim_r == LAST_IDX) ? '0 : victim_r + 1'b1;
              end else begin
                count_r <= count_r + 1'b1;
              end
            end
          end
        end
        ST_OUT: begin
          // Hold the result until the output register is free
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_status_r <= miss_r;
            out_value_r  <= sel_val_r ? VALUE_W'(val_q) : '0;
            out_count_r  <= COUNT_W'(count_r);
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W - VALUE_W - COUNT_W){1'b0}}, out_count_r, out_value_r};

endmodule

// ===== hdl/acrr_checker.sv =====
// Port-level checks for the associative store, bound to the top level.
// Depends on acrr_pkg; watches only the ports of assoc_cache_round_robin.
module acrr_checker
  import acrr_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A miss never carries a value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[VALUE_W-1:0] == '0)
    else $error("missed get returned a non-zero value");

  // The count never exceeds the store size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ENTRIES > 31) || (out_tdata[VALUE_W +: COUNT_W] <= COUNT_W'(ENTRIES)))
    else $error("entry count beyond store size");

  // One word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");

endmodule

bind assoc_cache_round_robin acrr_checker #(.ENTRIES(ENTRIES)) u_acrr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
